// ===== hw/rtl/dmx_htp_merge_engine_assert.svh =====
// Assertion macros shared by the DMX HTP merge engine RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef DMX_HTP_MERGE_ENGINE_ASSERT_SVH
`define DMX_HTP_MERGE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMX_HTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dmx_htp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMX_HTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dmx_htp: next-cycle check failed");

`endif

// ===== hw/rtl/dmx_htp_pkg.sv =====
// Package for the DMX HTP merge engine: field widths, codes, FSM types, structs.
// No dependencies.
package dmx_htp_pkg;

	localparam int UNIVERSES_DEF = 4;
	localparam int CHANNELS_DEF  = 512;

	localparam int UNIV_W  = 2;
	localparam int CHAN_W  = 9;
	localparam int LEVEL_W = 16;
	localparam int VALUE_W = 8;
	localparam int PROD_W  = LEVEL_W + VALUE_W;

	localparam logic [VALUE_W-1:0] DMX_FULL = 8'hFF;

	// quotient bits resolved one per iteration
	localparam int DIV_STEPS = VALUE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic {
		CMD_CONTRIBUTE = 1'b0,
		CMD_COMMIT     = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WRITE
	} seq_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_CHECK,
		DIV_ITER,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic               start;
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] full_scale;
	} div_ctl_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] value;
		logic               sat;
	} div_res_t;

endpackage

// ===== hw/rtl/dmx_htp_if.sv =====
// Valid/ready channel interfaces for the DMX HTP merge engine request and response words.
// Depends on dmx_htp_pkg.
interface dmx_htp_req_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [dmx_htp_pkg::UNIV_W-1:0]   universe;
	logic [dmx_htp_pkg::CHAN_W-1:0]   channel;
	logic [dmx_htp_pkg::LEVEL_W-1:0]  level;
	logic [dmx_htp_pkg::LEVEL_W-1:0]  full_scale;

	modport source (output valid, cmd, universe, channel, level, full_scale, input ready);
	modport sink   (input valid, cmd, universe, channel, level, full_scale, output ready);
endinterface

interface dmx_htp_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dmx_htp_pkg::VALUE_W-1:0]  value;
	logic                             changed;
	logic                             scale_error;

	modport source (output valid, value, changed, scale_error, input ready);
	modport sink   (input valid, value, changed, scale_error, output ready);
endinterface

// ===== hw/rtl/dmx_htp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmx_htp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/dmx_htp_div.sv =====
// Iterative level scaler: level*255/full_scale, saturated at 255, one shared subtractor.
// Depends on dmx_htp_pkg.
module dmx_htp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmx_htp_pkg::div_ctl_t ctl,
	output dmx_htp_pkg::div_res_t res
);

	localparam int LW = dmx_htp_pkg::LEVEL_W;
	localparam int VW = dmx_htp_pkg::VALUE_W;
	localparam int PW = dmx_htp_pkg::PROD_W;
	localparam int CW = dmx_htp_pkg::DIV_CNT_W;

	dmx_htp_pkg::div_state_t state_q, state_d;

	logic [LW-1:0] rem_q;
	logic [VW-1:0] low_q;
	logic [LW-1:0] full_q;
	logic          sat_q;
	logic [CW-1:0] cnt_q;

	logic [PW-1:0] prod;
	logic [LW:0]   sub_a;
	logic [LW+1:0] diff;
	logic          borrow;

	// level*255 as (level<<8) - level
	assign prod = {ctl.level, {VW{1'b0}}} - {{VW{1'b0}}, ctl.level};

	// shared subtractor: range check first, then one quotient bit per step
	assign sub_a  = (state_q == dmx_htp_pkg::DIV_CHECK) ? {1'b0, rem_q} : {rem_q, low_q[VW-1]};
	assign diff   = {1'b0, sub_a} - {2'b00, full_q};
	assign borrow = diff[LW+1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			dmx_htp_pkg::DIV_IDLE: begin
				if (ctl.start) state_d = dmx_htp_pkg::DIV_CHECK;
			end
			dmx_htp_pkg::DIV_CHECK: begin
				state_d = borrow ? dmx_htp_pkg::DIV_ITER : dmx_htp_pkg::DIV_DONE;
			end
			dmx_htp_pkg::DIV_ITER: begin
				if (cnt_q == CW'(dmx_htp_pkg::DIV_STEPS - 1)) state_d = dmx_htp_pkg::DIV_DONE;
			end
			dmx_htp_pkg::DIV_DONE: begin
				state_d = dmx_htp_pkg::DIV_IDLE;
			end
			default: begin
				state_d = dmx_htp_pkg::DIV_IDLE;
			end
		endcase
	end

	always_comb begin
		res.done  = (state_q == dmx_htp_pkg::DIV_DONE);
		res.sat   = sat_q;
		res.value = sat_q ? dmx_htp_pkg::DMX_FULL : low_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmx_htp_pkg::DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dmx_htp_pkg::DIV_ITER) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dmx_htp_pkg::DIV_IDLE: begin
				if (ctl.start) begin
					rem_q  <= prod[PW-1:VW];
					low_q  <= prod[VW-1:0];
					full_q <= ctl.full_scale;
				end
			end
			dmx_htp_pkg::DIV_CHECK: begin
				// quotient >= 256 iff high part >= divisor; zero divisor lands here too
				sat_q <= !borrow;
			end
			dmx_htp_pkg::DIV_ITER: begin
				if (!borrow) begin
					rem_q <= diff[LW-1:0];
					low_q <= {low_q[VW-2:0], 1'b1};
				end else begin
					rem_q <= sub_a[LW-1:0];
					low_q <= {low_q[VW-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/dmx_htp_merge_engine.sv =====
// Top level of the DMX highest-takes-precedence merge engine.
// Depends on dmx_htp_pkg, dmx_htp_if, dmx_htp_ram, dmx_htp_div and the assertion header.
//
// Usage:
//   req  : request words (cmd, universe, channel, level, full_scale), valid/ready.
//   rsp  : one response word per request (value, changed, scale_error), valid/ready.
//   cmd contribute scales level*255/full_scale (saturated, zero divisor flagged)
//   and keeps the larger of it and the stored merge byte. cmd commit returns the
//   merged byte, flags a change against the last output byte, stores it as the
//   new output byte and clears the merge byte.
// Sequence:
//   commit     : after the accept, ST_WRITE loads the response register when free.
//   contribute : ST_DIV waits on the radix-2 divider, one shared subtractor that
//                runs a range check, then steps 8 quotient bits only when the
//                quotient fits in 8 bits (not when it saturates or full_scale
//                is zero); then ST_WRITE loads the response register when free.
//   One request is in flight at a time; req.ready is high only when idle.
// Reset:
//   After arst_n releases, a clearing pass writes zero to both frame stores,
//   all UNIVERSES*CHANNELS entries (2048 at defaults); req.ready stays low meanwhile.
// Stall:
//   The response register lets the next request be accepted while a word waits;
//   that request then holds in its final step until rsp.ready frees the register.
`include "dmx_htp_merge_engine_assert.svh"

module dmx_htp_merge_engine #(
	parameter int UNIVERSES = dmx_htp_pkg::UNIVERSES_DEF,
	parameter int CHANNELS  = dmx_htp_pkg::CHANNELS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	dmx_htp_req_if.sink   req,
	dmx_htp_rsp_if.source rsp
);

	localparam int DEPTH = UNIVERSES * CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = dmx_htp_pkg::VALUE_W;

	dmx_htp_pkg::seq_state_t state_q, state_d;

	// request context
	logic          cmd_q;
	logic          ok_q;
	logic [AW-1:0] slot_q;

	// clearing pass address
	logic [AW-1:0] clr_cnt_q;
	logic          clr_last;

	// response register
	logic          out_valid_q;
	logic [VW-1:0] value_q;
	logic          changed_q;
	logic          err_q;

	logic          accept;
	logic          in_ok;
	logic [AW-1:0] in_slot;
	logic          out_free;
	logic          out_load;

	// store ports
	logic          mrg_we, lst_we, rd_en;
	logic [AW-1:0] wr_addr;
	logic [VW-1:0] mrg_wdata, lst_wdata;
	logic [VW-1:0] mrg_rdata, lst_rdata;

	// response word being formed
	logic [VW-1:0] res_value;
	logic          res_changed;
	logic          res_err;

	dmx_htp_pkg::div_ctl_t div_ctl;
	dmx_htp_pkg::div_res_t div_res;

	assign accept   = req.valid && req.ready;
	assign in_ok    = (32'(req.universe) < UNIVERSES) && (32'(req.channel) < CHANNELS);
	assign in_slot  = AW'(32'(req.universe) * CHANNELS + 32'(req.channel));
	assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign out_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmx_htp_pkg::ST_CLEAR: begin
				if (clr_last) state_d = dmx_htp_pkg::ST_IDLE;
			end
			dmx_htp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == dmx_htp_pkg::CMD_COMMIT) ? dmx_htp_pkg::ST_WRITE
						: dmx_htp_pkg::ST_DIV;
				end
			end
			dmx_htp_pkg::ST_DIV: begin
				if (div_res.done) state_d = dmx_htp_pkg::ST_WRITE;
			end
			dmx_htp_pkg::ST_WRITE: begin
				if (out_free) state_d = dmx_htp_pkg::ST_IDLE;
			end
			default: begin
				state_d = dmx_htp_pkg::ST_IDLE;
			end
		endcase
	end

	// response word: contribute reports the scaler, commit reports the merge byte
	always_comb begin
		if (cmd_q == dmx_htp_pkg::CMD_COMMIT) begin
			res_value   = ok_q ? mrg_rdata : '0;
			res_changed = ok_q && (mrg_rdata != lst_rdata);
			res_err     = 1'b0;
		end else begin
			res_value   = div_res.value;
			res_changed = 1'b0;
			res_err     = div_res.sat;
		end
	end

	// outputs of the sequencer
	always_comb begin
		req.ready         = 1'b0;
		div_ctl.start     = 1'b0;
		div_ctl.level     = req.level;
		div_ctl.full_scale = req.full_scale;
		rd_en             = 1'b0;
		mrg_we            = 1'b0;
		lst_we            = 1'b0;
		wr_addr           = slot_q;
		mrg_wdata         = '0;
		lst_wdata         = mrg_rdata;
		out_load          = 1'b0;
		case (state_q)
			dmx_htp_pkg::ST_CLEAR: begin
				mrg_we    = 1'b1;
				lst_we    = 1'b1;
				wr_addr   = clr_cnt_q;
				lst_wdata = '0;
			end
			dmx_htp_pkg::ST_IDLE: begin
				req.ready     = 1'b1;
				rd_en         = accept;
				div_ctl.start = accept && (req.cmd == dmx_htp_pkg::CMD_CONTRIBUTE);
			end
			dmx_htp_pkg::ST_WRITE: begin
				out_load = out_free;
				if (cmd_q == dmx_htp_pkg::CMD_COMMIT) begin
					mrg_we = out_free && ok_q;
					lst_we = out_free && ok_q;
				end else begin
					// unsigned HTP: keep the larger byte
					mrg_we    = out_free && ok_q && (div_res.value > mrg_rdata);
					mrg_wdata = div_res.value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmx_htp_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dmx_htp_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			ok_q   <= in_ok;
			slot_q <= in_slot;
		end
		if (out_load) begin
			value_q   <= res_value;
			changed_q <= res_changed;
			err_q     <= res_err;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.value       = value_q;
	assign rsp.changed     = changed_q;
	assign rsp.scale_error = err_q;

	dmx_htp_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_merge_ram (
		.clk   (clk),
		.we    (mrg_we),
		.waddr (wr_addr),
		.wdata (mrg_wdata),
		.re    (rd_en),
		.raddr (in_slot),
		.rdata (mrg_rdata)
	);

	dmx_htp_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH)
	) u_last_ram (
		.clk   (clk),
		.we    (lst_we),
		.waddr (wr_addr),
		.wdata (lst_wdata),
		.re    (rd_en),
		.raddr (in_slot),
		.rdata (lst_rdata)
	);

	dmx_htp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.res    (div_res)
	);

	// checks
	`DMX_HTP_ASSERT_SAME(a_no_accept_in_clear, clk, arst_n,
		state_q == dmx_htp_pkg::ST_CLEAR, !req.ready)
	`DMX_HTP_ASSERT_SAME(a_load_only_when_free, clk, arst_n,
		out_load, !out_valid_q || rsp.ready)
	`DMX_HTP_ASSERT_SAME(a_commit_clears_merge, clk, arst_n,
		mrg_we && state_q == dmx_htp_pkg::ST_WRITE && cmd_q == dmx_htp_pkg::CMD_COMMIT,
		mrg_wdata == '0)
	`DMX_HTP_ASSERT_SAME(a_div_done_while_waiting, clk, arst_n,
		div_res.done, state_q == dmx_htp_pkg::ST_DIV)
	`DMX_HTP_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n,
		accept, state_q != dmx_htp_pkg::ST_IDLE)

endmodule
